// File: sv/lshi_pkg.sv
package lshi_pkg;

  // Fixed field and state widths.
  localparam int SECTORS    = 8;
  localparam int SECTOR_W   = 3;
  localparam int ANGLE_W    = 16;
  localparam int DIST_IN_W  = 18;
  localparam int DIST_W     = 16;
  localparam int QUAL_W     = 8;
  localparam int SUM_W      = 20;
  localparam int CNT_W      = 4;
  localparam int FAR_W      = 14;
  localparam int MODES_W    = 16;
  localparam int LEVEL_W    = 8;
  localparam int DEN_W      = FAR_W + CNT_W;
  localparam int NUM_W      = DEN_W + LEVEL_W;
  localparam int BIT_IDX_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Half a sector in Q14 angle units, used to round to the nearest sector.
  localparam logic [ANGLE_W-1:0] ANGLE_ROUND = 16'd4096;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SECTOR_MODES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUALITY_FLOOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_DISTANCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_DISTANCE  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [MODES_W-1:0] RST_SECTOR_MODES  = 16'h5555;
  localparam logic [QUAL_W-1:0]  RST_QUALITY_FLOOR = 8'd60;
  localparam logic [DIST_W-1:0]  RST_NEAR_DISTANCE = 16'd300;
  localparam logic [FAR_W-1:0]   RST_FAR_DISTANCE  = 14'd3000;

  // Per-sector mode codes.
  localparam logic [1:0] MODE_AVERAGE    = 2'd0;
  localparam logic [1:0] MODE_MINIMUM    = 2'd1;
  localparam logic [1:0] MODE_CUMULATIVE = 2'd2;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CMP,
    ST_SCALE,
    ST_OVF,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// File: sv/lidar_sector_haptic_intensity_core.sv
// Sequence: an emitting sample passes PREP and CMP, then SCALE, OVF and the eight steps of the
// restoring divider when the divider runs, SCALE and OVF alone when the quotient clamps at full
// drive, and neither when the compare settles the level alone; every path ends in OUT. The input
// is stalled from an emitting sample's accept until its result is taken, output stalls included;
// a dropped or non-emitting sample does not stall it. A shared subtractor runs the arithmetic.
// Reset (rst, synchronous, active high) restores register defaults and empties every sector.
module lidar_sector_haptic_intensity_core #(
  parameter int BLOCK_LENGTH = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [lshi_pkg::ANGLE_W-1:0]         angle_q14,
  input  logic [lshi_pkg::DIST_IN_W-1:0]       distance_q2,
  input  logic [lshi_pkg::QUAL_W-1:0]          quality,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [lshi_pkg::SECTOR_W-1:0]        sector,
  output logic [lshi_pkg::LEVEL_W-1:0]         intensity,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lshi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lshi_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // The block length is stored in the four-bit fill counter.
  localparam logic [lshi_pkg::CNT_W-1:0] BLOCK_LEN = lshi_pkg::CNT_W'(BLOCK_LENGTH);

  // Configuration registers.
  logic [lshi_pkg::MODES_W-1:0] sector_modes;
  logic [lshi_pkg::QUAL_W-1:0]  quality_floor;
  logic [lshi_pkg::DIST_W-1:0]  near_distance;
  logic [lshi_pkg::FAR_W-1:0]   far_distance;

  // Per-sector block state. Only eight entries, read at the one sector that the
  // incoming request selects, so they live in flip-flops and reset clears them.
  logic [lshi_pkg::SUM_W-1:0]  block_sum  [lshi_pkg::SECTORS];
  logic [lshi_pkg::DIST_W-1:0] block_min  [lshi_pkg::SECTORS];
  logic [lshi_pkg::CNT_W-1:0]  fill_count [lshi_pkg::SECTORS];

  lshi_pkg::state_t state, state_next;

  // Operands of the intensity calculation and the divider's working registers.
  logic [lshi_pkg::SUM_W-1:0]     op_total;
  logic [lshi_pkg::CNT_W-1:0]     op_count;
  logic [lshi_pkg::DEN_W-1:0]     fc;
  logic [lshi_pkg::DEN_W-1:0]     den;
  logic                           far_gt_near;
  logic [lshi_pkg::NUM_W-1:0]     rem;
  logic [lshi_pkg::LEVEL_W-1:0]   quot;
  logic [lshi_pkg::BIT_IDX_W-1:0] bit_idx;

  // Decode of the incoming request. The sector is the angle rounded to the
  // nearest 45 degrees; the 16-bit add wraps, which gives the modulo-8 wrap
  // towards north for free.
  logic                          in_accept;
  logic [lshi_pkg::ANGLE_W-1:0]  angle_rounded;
  logic [lshi_pkg::SECTOR_W-1:0] in_sector;
  logic [lshi_pkg::DIST_W-1:0]   in_dist;
  logic [1:0]                    in_mode;
  logic                          in_keep;
  logic [lshi_pkg::SUM_W-1:0]    new_sum;
  logic [lshi_pkg::DIST_W-1:0]   new_min;
  logic [lshi_pkg::CNT_W-1:0]    new_count;
  logic                          block_full;
  logic                          emit;

  assign in_accept     = in_valid && !in_stall;
  assign angle_rounded = angle_q14 + lshi_pkg::ANGLE_ROUND;
  assign in_sector     = angle_rounded[lshi_pkg::ANGLE_W-1 -: lshi_pkg::SECTOR_W];
  assign in_dist       = distance_q2[lshi_pkg::DIST_IN_W-1:2];
  assign in_mode       = sector_modes[{in_sector, 1'b0} +: 2];
  assign in_keep       = quality >= quality_floor;
  assign new_sum       = block_sum[in_sector] + lshi_pkg::SUM_W'(in_dist);
  assign new_min       = (in_dist >= near_distance && in_dist < block_min[in_sector]) ?
                         in_dist : block_min[in_sector];
  assign new_count     = fill_count[in_sector] + 1'b1;
  assign block_full    = new_count >= BLOCK_LEN;
  assign emit          = block_full || (in_mode == lshi_pkg::MODE_CUMULATIVE);

  // Far minus near, signed by one extra bit. When far exceeds near the
  // difference fits the far register's width.
  logic [lshi_pkg::DIST_W:0] far_minus_near;
  assign far_minus_near = {3'b000, far_distance} - {1'b0, near_distance};

  // The shared subtractor. Every arithmetic step after the setup state goes
  // through it: the beyond-far compare, the scaling by 255 (x*256 - x), the
  // overflow check against den*256 and each restoring-division step.
  logic [lshi_pkg::NUM_W-1:0] sub_a, sub_b;
  logic [lshi_pkg::NUM_W:0]   sub_diff;
  logic                       sub_ge;
  logic                       sub_zero;

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state)
      lshi_pkg::ST_CMP: begin
        sub_a = lshi_pkg::NUM_W'(fc);
        sub_b = lshi_pkg::NUM_W'(op_total);
      end
      lshi_pkg::ST_SCALE: begin
        sub_a = {rem[lshi_pkg::DEN_W-1:0], 8'd0};
        sub_b = rem;
      end
      lshi_pkg::ST_OVF: begin
        sub_a = rem;
        sub_b = {den, 8'd0};
      end
      lshi_pkg::ST_DIV: begin
        sub_a = rem;
        sub_b = lshi_pkg::NUM_W'(den) << bit_idx;
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[lshi_pkg::NUM_W];
  assign sub_zero = sub_diff == '0;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      lshi_pkg::ST_IDLE: begin
        if (in_accept && in_keep && emit) begin
          state_next = lshi_pkg::ST_PREP;
        end
      end
      lshi_pkg::ST_PREP: begin
        state_next = lshi_pkg::ST_CMP;
      end
      lshi_pkg::ST_CMP: begin
        // Total at or beyond far, in every mode, or far not above near: the
        // level is settled without dividing.
        if (!sub_ge || sub_zero || !far_gt_near) begin
          state_next = lshi_pkg::ST_OUT;
        end else begin
          state_next = lshi_pkg::ST_SCALE;
        end
      end
      lshi_pkg::ST_SCALE: begin
        state_next = lshi_pkg::ST_OVF;
      end
      lshi_pkg::ST_OVF: begin
        state_next = sub_ge ? lshi_pkg::ST_OUT : lshi_pkg::ST_DIV;
      end
      lshi_pkg::ST_DIV: begin
        if (bit_idx == '0) begin
          state_next = lshi_pkg::ST_OUT;
        end
      end
      lshi_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_next = lshi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lshi_pkg::ST_IDLE;
      end
    endcase
  end

  // Handshake outputs follow the state alone. The configuration port never
  // pushes back.
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cfg_ready = 1'b1;
    case (state)
      lshi_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      lshi_pkg::ST_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
      end
    endcase
  end

  // Control state, configuration and per-sector block state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lshi_pkg::ST_IDLE;
      sector_modes  <= lshi_pkg::RST_SECTOR_MODES;
      quality_floor <= lshi_pkg::RST_QUALITY_FLOOR;
      near_distance <= lshi_pkg::RST_NEAR_DISTANCE;
      far_distance  <= lshi_pkg::RST_FAR_DISTANCE;
      for (int s = 0; s < lshi_pkg::SECTORS; s++) begin
        block_sum[s]  <= '0;
        block_min[s]  <= '1;
        fill_count[s] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lshi_pkg::REG_SECTOR_MODES:  sector_modes  <= cfg_data;
          lshi_pkg::REG_QUALITY_FLOOR: quality_floor <= cfg_data[lshi_pkg::QUAL_W-1:0];
          lshi_pkg::REG_NEAR_DISTANCE: near_distance <= cfg_data;
          lshi_pkg::REG_FAR_DISTANCE:  far_distance  <= cfg_data[lshi_pkg::FAR_W-1:0];
          default: begin
          end
        endcase
      end

      // A kept sample joins its sector's block at once; a full block is
      // emptied in the same cycle, its totals having been copied to the
      // operand registers below.
      if (in_accept && in_keep) begin
        if (block_full) begin
          block_sum[in_sector]  <= '0;
          block_min[in_sector]  <= '1;
          fill_count[in_sector] <= '0;
        end else begin
          block_sum[in_sector]  <= new_sum;
          block_min[in_sector]  <= new_min;
          fill_count[in_sector] <= new_count;
        end
      end
    end
  end

  // Datapath registers: no reset needed, each is loaded before it is used.
  always_ff @(posedge clk) begin
    case (state)
      lshi_pkg::ST_IDLE: begin
        if (in_accept && in_keep) begin
          sector <= in_sector;
          // Minimum mode works on the block minimum as a value over a count
          // of one; the other modes on the block sum over its fill count.
          if (in_mode == lshi_pkg::MODE_MINIMUM) begin
            op_total <= lshi_pkg::SUM_W'(new_min);
            op_count <= lshi_pkg::CNT_W'(1);
          end else begin
            op_total <= new_sum;
            op_count <= new_count;
          end
        end
      end
      lshi_pkg::ST_PREP: begin
        fc          <= far_distance * op_count;
        den         <= far_minus_near[lshi_pkg::FAR_W-1:0] * op_count;
        far_gt_near <= !far_minus_near[lshi_pkg::DIST_W] && (far_minus_near != '0);
      end
      lshi_pkg::ST_CMP: begin
        rem <= sub_diff[lshi_pkg::NUM_W-1:0];
        if (!sub_ge || sub_zero) begin
          intensity <= '0;
        end else if (!far_gt_near) begin
          intensity <= lshi_pkg::LEVEL_FULL;
        end
      end
      lshi_pkg::ST_SCALE: begin
        rem     <= sub_diff[lshi_pkg::NUM_W-1:0];
        quot    <= '0;
        bit_idx <= '1;
      end
      lshi_pkg::ST_OVF: begin
        // A quotient of 256 or more clamps to full drive.
        if (sub_ge) begin
          intensity <= lshi_pkg::LEVEL_FULL;
        end
      end
      lshi_pkg::ST_DIV: begin
        if (sub_ge) begin
          rem <= sub_diff[lshi_pkg::NUM_W-1:0];
        end
        quot    <= quot | (sub_ge ? (lshi_pkg::LEVEL_W'(1) << bit_idx) : '0);
        bit_idx <= bit_idx - 1'b1;
        if (bit_idx == '0) begin
          intensity <= quot | lshi_pkg::LEVEL_W'(sub_ge);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: test/lidar_sector_haptic_intensity_checker.sv
module lidar_sector_haptic_intensity_checker #(
  parameter int BLOCK_LENGTH = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [lshi_pkg::ANGLE_W-1:0]       angle_q14,
  input  logic [lshi_pkg::DIST_IN_W-1:0]     distance_q2,
  input  logic [lshi_pkg::QUAL_W-1:0]        quality,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [lshi_pkg::SECTOR_W-1:0]      sector,
  input  logic [lshi_pkg::LEVEL_W-1:0]       intensity,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [lshi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lshi_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                 failures,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lshi_pkg::*;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [LEVEL_W-1:0]  level;
  } haptic_t;

  logic [MODES_W-1:0] modes_r;
  logic [QUAL_W-1:0]  floor_r;
  logic [DIST_W-1:0]  near_r;
  logic [FAR_W-1:0]   far_r;

  logic [SUM_W-1:0]   sum_r  [SECTORS];
  logic [DIST_W-1:0]  min_r  [SECTORS];
  logic [CNT_W-1:0]   fill_r [SECTORS];

  haptic_t haptic_q[$];
  int      fail_count = 0;

  // Drive level for the distance total/count against the current near and far.
  function automatic logic [LEVEL_W-1:0] drive_level(input longint unsigned total,
                                                     input longint unsigned count);
    longint unsigned f;
    longint unsigned n;
    longint unsigned q;
    f = far_r;
    n = near_r;
    if (total >= f * count) return '0;
    if (f <= n) return LEVEL_FULL;
    q = ((f * count - total) * 64'(LEVEL_FULL)) / (count * (f - n));
    return (q > 64'(LEVEL_FULL)) ? LEVEL_FULL : q[LEVEL_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [ANGLE_W:0]    rounded;
    logic [SECTOR_W-1:0] s;
    logic [1:0]          mode;
    logic [DIST_W-1:0]   dist_mm;
    logic                full;
    haptic_t             want;
    if (rst) begin
      modes_r = RST_SECTOR_MODES;
      floor_r = RST_QUALITY_FLOOR;
      near_r  = RST_NEAR_DISTANCE;
      far_r   = RST_FAR_DISTANCE;
      for (int i = 0; i < SECTORS; i++) begin
        sum_r[i]  = '0;
        min_r[i]  = '1;
        fill_r[i] = '0;
      end
      haptic_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (haptic_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got sector %0d intensity %0d",
                   $time, sector, intensity);
          fail_count++;
        end else begin
          want = haptic_q.pop_front();
          if (sector !== want.sector) begin
            $display("%0t: sector mismatch, expected %0d, got %0d",
                     $time, want.sector, sector);
            fail_count++;
          end
          if (intensity !== want.level) begin
            $display("%0t: intensity mismatch (sector %0d), expected %0d, got %0d",
                     $time, want.sector, want.level, intensity);
            fail_count++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SECTOR_MODES:  modes_r = cfg_data[MODES_W-1:0];
          REG_QUALITY_FLOOR: floor_r = cfg_data[QUAL_W-1:0];
          REG_NEAR_DISTANCE: near_r  = cfg_data[DIST_W-1:0];
          REG_FAR_DISTANCE:  far_r   = cfg_data[FAR_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall && quality >= floor_r) begin
        rounded = {1'b0, angle_q14} + {1'b0, ANGLE_ROUND};
        s       = rounded[ANGLE_W-1:ANGLE_W-SECTOR_W];
        mode    = modes_r[2*s +: 2];
        dist_mm = distance_q2[DIST_IN_W-1:2];

        sum_r[s] = sum_r[s] + SUM_W'(dist_mm);
        if (dist_mm >= near_r && dist_mm < min_r[s]) min_r[s] = dist_mm;
        fill_r[s] = fill_r[s] + 1'b1;
        full = (fill_r[s] >= BLOCK_LENGTH);

        if (full || mode == MODE_CUMULATIVE) begin
          want.sector = s;
          if (mode == MODE_MINIMUM) want.level = drive_level(min_r[s], 1);
          else want.level = drive_level(sum_r[s], fill_r[s]);
          haptic_q.push_back(want);
        end
        if (full) begin
          sum_r[s]  = '0;
          min_r[s]  = '1;
          fill_r[s] = '0;
        end
      end
    end
    failures <= fail_count;
    pending  <= haptic_q.size();
  end

endmodule

// File: test/lidar_sector_haptic_intensity_core_test.sv
module lidar_sector_haptic_intensity_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lshi_pkg::*;

  localparam int BLOCK_LENGTH    = 10;
  // Settling margin after the last predicted result; it covers the core's path from request to result.
  localparam int SETTLE_CYCLES   = 20;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_CYCLES     = 400;
  localparam int TIMEOUT_NS      = 1_000_000;

  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [ANGLE_W-1:0]    angle_q14   = '0;
  logic [DIST_IN_W-1:0]  distance_q2 = '0;
  logic [QUAL_W-1:0]     quality     = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [SECTOR_W-1:0]   sector;
  logic [LEVEL_W-1:0]    intensity;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  int fail_total;
  int results_owed;

  // Idling rates in per cent, set by the stimulus and read by the sender and the receiver.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Each increment asks the receiver for one long hold-off.
  int hold_requests = 0;

  // Register values as last written, used to steer the random samples.
  int cur_floor = RST_QUALITY_FLOOR;
  int cur_near  = RST_NEAR_DISTANCE;
  int cur_far   = RST_FAR_DISTANCE;

  lidar_sector_haptic_intensity_core #(
    .BLOCK_LENGTH(BLOCK_LENGTH)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .angle_q14(angle_q14), .distance_q2(distance_q2), .quality(quality),
    .out_valid(out_valid), .out_stall(out_stall),
    .sector(sector), .intensity(intensity),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lidar_sector_haptic_intensity_checker #(
    .BLOCK_LENGTH(BLOCK_LENGTH)
  ) haptic_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .angle_q14(angle_q14), .distance_q2(distance_q2), .quality(quality),
    .out_valid(out_valid), .out_stall(out_stall),
    .sector(sector), .intensity(intensity),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(fail_total), .pending(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A hard stop in case the core locks up or a handshake is never completed.
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // The receiver changes its stall at the falling edge. A pending hold-off request takes
  // priority and keeps the output stalled for a long, counted stretch, so that the core
  // backs up and has to stall its own input.
  initial begin : receiver
    int holds_done;
    int hold_left;
    holds_done = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (($urandom % 100) < recv_idle_pct);
      end
    end
  end

  // Offers one sample request. It is entered and left at a falling edge, with valid still
  // high on the way out, so that a following request can be offered without a gap.
  task automatic drive_sample(input logic [ANGLE_W-1:0] a, input logic [DIST_IN_W-1:0] d,
                              input logic [QUAL_W-1:0] q);
    while (($urandom % 100) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    angle_q14   <= a;
    distance_q2 <= d;
    quality     <= q;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // One register write request; valid is left high for the caller to lower.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Writes all four registers back to back. The floor and far words may carry bits above
  // the register width, which the core is meant to drop.
  task automatic program_registers(input logic [CFG_DATA_W-1:0] modes,
                                   input logic [CFG_DATA_W-1:0] floor_word,
                                   input logic [CFG_DATA_W-1:0] near,
                                   input logic [CFG_DATA_W-1:0] far_word);
    write_register(REG_SECTOR_MODES, modes);
    write_register(REG_QUALITY_FLOOR, floor_word);
    write_register(REG_NEAR_DISTANCE, near);
    write_register(REG_FAR_DISTANCE, far_word);
    cfg_valid <= 1'b0;
    cur_floor = floor_word[QUAL_W-1:0];
    cur_near  = near;
    cur_far   = far_word[FAR_W-1:0];
  endtask

  // Stops offering requests until every predicted result has been seen, then lets the core
  // settle, since a sample that gives no result may still be in flight.
  task automatic await_results();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [ANGLE_W-1:0]   angle_v;
    logic [DIST_IN_W-1:0] dist_v;
    logic [QUAL_W-1:0]    qual_v;
    int                   mm;
    int                   lim;
    int                   pick;
    int                   kept;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Sector 0 averages, sector 1 takes the minimum, sector 2 and sectors
    // 4 to 7 are cumulative and sector 3 uses the spare code, which also averages.
    send_idle_pct = 26;
    recv_idle_pct = 63;
    program_registers(16'hAAE4, 16'd60, 16'd300, 16'd3000);

    // A minimum block where no sample reaches the near distance gives zero.
    for (int i = 0; i < BLOCK_LENGTH; i++) drive_sample(16'd8192, 18'd400, 8'd90);

    drive_sample(16'd32768, 18'd4000, 8'd59);    // just under the floor, so dropped
    drive_sample(16'd32768, 18'd0, 8'd60);       // at the floor, zero distance, full level
    drive_sample(16'd32768, 18'd12000, 8'd255);
    drive_sample(16'd49152, 18'd12000, 8'd200);  // exactly at far gives zero
    drive_sample(16'd57344, 18'd11996, 8'd200);  // one millimetre short of far
    drive_sample(16'd40960, 18'd1200, 8'd200);   // exactly at near
    drive_sample(16'd16384, 18'd12003, 8'd200);  // quarter-millimetre bits are dropped
    drive_sample(16'd0, 18'h3FFFF, 8'd255);      // largest distance
    drive_sample(16'hFFFF, 18'd4000, 8'd0);      // wraps to sector 0 but is dropped
    drive_sample(16'hFFFF, 18'd4000, 8'd255);    // wraps to sector 0
    drive_sample(16'd4095, 18'd8000, 8'd100);    // just below a half sector
    drive_sample(16'd4096, 18'd8000, 8'd100);    // a tie rounds up into sector 1
    drive_sample(16'd61439, 18'd8000, 8'd100);   // still sector 7
    drive_sample(16'd61440, 18'd8000, 8'd100);   // rounds to 8 and wraps to sector 0

    // Random part in six register settings. The first two have the sender idling less than
    // the receiver, the next two the other way round, and the last two no idling at all.
    for (int phase = 0; phase < 6; phase++) begin
      await_results();
      case (phase)
        0: program_registers(16'($urandom), 16'd60, 16'd300, 16'd3000);
        1: program_registers(16'h0000, 16'd0, 16'd0, 16'd9998);
        // Far below near throughout; the floor and far words also carry bits above the register widths.
        2: program_registers(16'hFFFF, 16'hABFF, 16'hFFFF, 16'hC001);
        3: program_registers(16'($urandom), 16'($urandom_range(0, 120)),
                             16'($urandom_range(0, 4000)), 16'($urandom));
        // A narrow band, so that clamping at full level is common.
        4: program_registers(16'hAAAA, 16'd128, 16'd1000, 16'd1200);
        default: program_registers(16'h5555, 16'd30, 16'd2000, 16'd5000);
      endcase
      send_idle_pct = (phase < 2) ? 26 : (phase < 4) ? 63 : 0;
      recv_idle_pct = (phase < 2) ? 63 : (phase < 4) ? 26 : 0;
      // Every sector is cumulative here, so every kept request makes a result and the long
      // hold-off fills the core up while the sender keeps offering.
      if (phase == 4) hold_requests++;

      kept = 0;
      while (kept < ITEMS_PER_PHASE) begin
        // Halfway through, the sender pauses until the core has delivered everything.
        if (kept == ITEMS_PER_PHASE / 2) await_results();

        if ($urandom_range(0, 9) < 7) angle_v = 16'($urandom);
        else angle_v = 16'($urandom_range(0, 7) * 8192 + 4096 + $urandom_range(0, 3) - 2);

        pick = $urandom_range(0, 9);
        lim  = ((cur_far > cur_near) ? cur_far : cur_near) + cur_far / 4 + 16;
        if (lim > 65535) lim = 65535;
        if (pick < 6) mm = $urandom_range(0, lim);
        else mm = cur_near + $urandom_range(0, 8) - 4;
        dist_v = {16'(mm), 2'($urandom)};
        if (pick == 8) dist_v = 18'($urandom);
        if (pick == 9) dist_v = ($urandom_range(0, 1) != 0) ? '1 : '0;

        if ($urandom_range(0, 9) < 8) qual_v = 8'($urandom_range(cur_floor, 255));
        else qual_v = 8'($urandom);

        drive_sample(angle_v, dist_v, qual_v);
        // Dropped samples do not count towards the phase.
        if (qual_v >= cur_floor) kept++;
      end
    end

    await_results();
    if (results_owed != 0) $display("%0d predicted results never arrived", results_owed);
    if (fail_total == 0 && results_owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: lidar_sector_haptic_intensity_core.f
sv/lshi_pkg.sv
sv/lidar_sector_haptic_intensity_core.sv
test/lidar_sector_haptic_intensity_checker.sv
test/lidar_sector_haptic_intensity_core_test.sv
